[rtl/source_text_lexer_assert.svh]
// Assertion macros used by the lexer RTL.
`ifndef SOURCE_TEXT_LEXER_ASSERT_SVH
`define SOURCE_TEXT_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define STL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/stl_pkg.sv]
package stl_pkg;

    localparam int TOKEN_KIND_W = 6;
    localparam int TOKEN_LINE_W = 24;
    localparam int TOKEN_OFFSET_W = 24;
    localparam int TOKEN_SIZE_W = 16;

    typedef logic [TOKEN_KIND_W-1:0] t_kind;
    typedef logic [7:0] t_char;

    typedef struct packed {
        t_kind                     kind;
        logic [TOKEN_LINE_W-1:0]   line;
        logic [TOKEN_OFFSET_W-1:0] offset;
        logic [TOKEN_SIZE_W-1:0]   size;
        logic                      last;
    } t_token;

    // Token codes
    localparam t_kind K_PLUS   = 6'd2;
    localparam t_kind K_MINUS  = 6'd3;
    localparam t_kind K_TIMES  = 6'd4;
    localparam t_kind K_DIV    = 6'd5;
    localparam t_kind K_EQU    = 6'd6;
    localparam t_kind K_GT     = 6'd7;
    localparam t_kind K_NJOIN  = 6'd8;
    localparam t_kind K_GTEQ   = 6'd9;
    localparam t_kind K_MOD    = 6'd10;
    localparam t_kind K_LT     = 6'd11;
    localparam t_kind K_LTEQ   = 6'd12;
    localparam t_kind K_NEQ    = 6'd13;
    localparam t_kind K_RANGE  = 6'd14;
    localparam t_kind K_LPAREN = 6'd15;
    localparam t_kind K_RPAREN = 6'd16;
    localparam t_kind K_LBRACK = 6'd17;
    localparam t_kind K_RBRACK = 6'd18;
    localparam t_kind K_NAME   = 6'd19;
    localparam t_kind K_INT    = 6'd20;
    localparam t_kind K_FLOAT  = 6'd21;
    localparam t_kind K_ARROW  = 6'd32;
    localparam t_kind K_EOF    = 6'd33;
    localparam t_kind K_SOF    = 6'd34;

    // Character codes
    localparam t_char CH_NUL    = 8'h00;
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_PERCENT = 8'h25;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RPAREN = 8'h29;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_0      = 8'h30;
    localparam t_char CH_9      = 8'h39;
    localparam t_char CH_SEMI   = 8'h3B;
    localparam t_char CH_LESS   = 8'h3C;
    localparam t_char CH_EQUAL  = 8'h3D;
    localparam t_char CH_GREATER = 8'h3E;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LBRACK = 8'h5B;
    localparam t_char CH_RBRACK = 8'h5D;
    localparam t_char CH_UNDER  = 8'h5F;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7A;
    localparam t_char CH_BAR    = 8'h7C;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_IDLE    = 4'd1,
        PH_MINUS   = 4'd2,
        PH_SLASH   = 4'd3,
        PH_LESS    = 4'd4,
        PH_GREATER = 4'd5,
        PH_DOT     = 4'd6,
        PH_BAR     = 4'd7,
        PH_NAME    = 4'd8,
        PH_NUM     = 4'd9,
        PH_COMMENT = 4'd10,
        PH_NUMDOT  = 4'd11
    } t_phase;

endpackage

[rtl/stl_char_if.sv]
interface stl_char_if ();
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink (input valid, input text_char, output ready);
endinterface

[rtl/stl_token_if.sv]
interface stl_tok_if import stl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_kind                     token_kind;
    logic [TOKEN_LINE_W-1:0]   token_line;
    logic [TOKEN_OFFSET_W-1:0] lexeme_offset;
    logic [TOKEN_SIZE_W-1:0]   lexeme_size;
    logic                      last_of_run;

    modport source (
        output valid, output token_kind, output token_line, output lexeme_offset,
        output lexeme_size, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_line, input lexeme_offset,
        input lexeme_size, input last_of_run, output ready
    );
endinterface

[rtl/source_text_lexer.sv]
// Channel   Dir  Payload                                           Transfer
// i_text    in   text_char                                         valid & ready
// o_token   out  token_kind token_line lexeme_offset lexeme_size   valid & ready
//                last_of_run
//
// One byte per cycle while i_text.ready is high; a byte is registered, then its tokens queued.
// Each byte yields zero to two tokens into an 8-entry output queue; the queue depth
// sets how far the output side may stall before i_text.ready drops.
// Reset (i_rst_n low at a clock edge) returns to the start of a text, line 1, offset 0.
// i_text.ready drops while queued tokens plus two slots held for the byte in flight
// leave under two free slots.
module source_text_lexer import stl_pkg::*; #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    stl_char_if.sink i_text,
    stl_tok_if.source o_token
);

    localparam int DEPTH = 8;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    function automatic logic is_digit(input t_char c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input t_char c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) || (c == CH_UNDER);
    endfunction

    // Input register
    logic  r_in_valid;
    t_char r_in_char;

    // Lexer state
    t_phase                   r_phase, n_phase;
    logic [LINE_BITS-1:0]     r_line, n_line;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [LENGTH_BITS-1:0]   r_count, n_count;
    logic                     r_saw, n_saw;

    // Output queue
    t_token           r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fifo_cnt;

    logic in_xfer;
    logic out_xfer;

    // start_byte decode
    t_phase sb_phase;
    logic   sb_tok_valid;
    t_kind  sb_kind;
    logic   sb_nl;
    logic   sb_lex;

    // Up to three candidate tokens: SOF, flushed pending token, new token
    logic                   a_valid;
    logic                   b_valid;
    t_kind                  b_kind;
    logic                   b_lex;
    logic [LENGTH_BITS-1:0] b_size;
    logic                   c_valid;
    t_kind                  c_kind;
    logic                   do_sb;
    t_phase                 pe;
    logic [LENGTH_BITS-1:0] cnt_p1;
    logic [LENGTH_BITS-1:0] cnt_p2;
    logic [LINE_BITS-1:0]   line_p1;
    logic [POSITION_BITS-1:0] pos_p1;

    t_token     tok_a, tok_b, tok_c;
    t_token     tok_first, tok_second;
    logic [1:0] push_cnt;
    logic [CNT_W:0] pending_slots;

    assign cnt_p1  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign cnt_p2  = (cnt_p1 == '1) ? cnt_p1 : cnt_p1 + 1'b1;
    assign line_p1 = (r_line == '1) ? r_line : r_line + 1'b1;
    assign pos_p1  = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign pe      = (r_phase == PH_START) ? PH_IDLE : r_phase;

    always_comb begin
        sb_phase     = PH_IDLE;
        sb_tok_valid = 1'b0;
        sb_kind      = K_PLUS;
        sb_nl        = 1'b0;
        sb_lex       = 1'b0;
        unique case (r_in_char)
            CH_NL:       sb_nl = 1'b1;
            CH_SEMI:     sb_phase = PH_COMMENT;
            CH_DOT:      sb_phase = PH_DOT;
            CH_BAR:      sb_phase = PH_BAR;
            CH_MINUS:    sb_phase = PH_MINUS;
            CH_SLASH:    sb_phase = PH_SLASH;
            CH_LESS:     sb_phase = PH_LESS;
            CH_GREATER:  sb_phase = PH_GREATER;
            CH_PLUS:     begin sb_tok_valid = 1'b1; sb_kind = K_PLUS;   end
            CH_STAR:     begin sb_tok_valid = 1'b1; sb_kind = K_TIMES;  end
            CH_PERCENT:  begin sb_tok_valid = 1'b1; sb_kind = K_MOD;    end
            CH_EQUAL:    begin sb_tok_valid = 1'b1; sb_kind = K_EQU;    end
            CH_LPAREN:   begin sb_tok_valid = 1'b1; sb_kind = K_LPAREN; end
            CH_RPAREN:   begin sb_tok_valid = 1'b1; sb_kind = K_RPAREN; end
            CH_LBRACK:   begin sb_tok_valid = 1'b1; sb_kind = K_LBRACK; end
            CH_RBRACK:   begin sb_tok_valid = 1'b1; sb_kind = K_RBRACK; end
            default: begin
                if (is_digit(r_in_char)) begin
                    sb_lex   = 1'b1;
                    sb_phase = PH_NUM;
                end else if (is_letter(r_in_char)) begin
                    sb_lex   = 1'b1;
                    sb_phase = PH_NAME;
                end
            end
        endcase
    end

    always_comb begin
        a_valid = (r_phase == PH_START);
        b_valid = 1'b0;
        b_kind  = K_MINUS;
        b_lex   = 1'b0;
        b_size  = r_count;
        c_valid = 1'b0;
        c_kind  = K_EOF;
        do_sb   = 1'b0;
        n_phase = pe;
        n_line  = r_line;
        n_pos   = pos_p1;
        n_begin = r_begin;
        n_count = r_count;
        n_saw   = r_saw;

        if (r_in_char == CH_NUL) begin
            // flush pending token, emit EOF, restart for the next text
            unique case (pe)
                PH_MINUS:   begin b_valid = 1'b1; b_kind = K_MINUS; end
                PH_SLASH:   begin b_valid = 1'b1; b_kind = K_DIV;   end
                PH_LESS:    begin b_valid = 1'b1; b_kind = K_LT;    end
                PH_GREATER: begin b_valid = 1'b1; b_kind = K_GT;    end
                PH_NAME:    begin b_valid = 1'b1; b_kind = K_NAME; b_lex = 1'b1; end
                PH_NUM: begin
                    b_valid = 1'b1;
                    b_kind  = r_saw ? K_FLOAT : K_INT;
                    b_lex   = 1'b1;
                end
                PH_NUMDOT: begin
                    b_valid = 1'b1;
                    b_kind  = K_FLOAT;
                    b_lex   = 1'b1;
                    b_size  = cnt_p1;
                end
                default: ;
            endcase
            c_valid = 1'b1;
            c_kind  = K_EOF;
            n_phase = PH_START;
            n_line  = LINE_BITS'(1);
            n_pos   = '0;
            n_count = '0;
            n_saw   = 1'b0;
        end else begin
            unique case (pe)
                PH_COMMENT: do_sb = (r_in_char == CH_NL);
                PH_MINUS: begin
                    if (r_in_char == CH_GREATER) begin
                        c_valid = 1'b1; c_kind = K_ARROW; n_phase = PH_IDLE;
                    end else begin
                        b_valid = 1'b1; b_kind = K_MINUS; do_sb = 1'b1;
                    end
                end
                PH_SLASH: begin
                    if (r_in_char == CH_EQUAL) begin
                        c_valid = 1'b1; c_kind = K_NEQ; n_phase = PH_IDLE;
                    end else begin
                        b_valid = 1'b1; b_kind = K_DIV; do_sb = 1'b1;
                    end
                end
                PH_LESS: begin
                    if (r_in_char == CH_EQUAL) begin
                        c_valid = 1'b1; c_kind = K_LTEQ; n_phase = PH_IDLE;
                    end else begin
                        b_valid = 1'b1; b_kind = K_LT; do_sb = 1'b1;
                    end
                end
                PH_GREATER: begin
                    if (r_in_char == CH_EQUAL) begin
                        c_valid = 1'b1; c_kind = K_GTEQ; n_phase = PH_IDLE;
                    end else begin
                        b_valid = 1'b1; b_kind = K_GT; do_sb = 1'b1;
                    end
                end
                PH_DOT: begin
                    if (r_in_char == CH_DOT) begin
                        c_valid = 1'b1; c_kind = K_RANGE; n_phase = PH_IDLE;
                    end else begin
                        do_sb = 1'b1;
                    end
                end
                PH_BAR: begin
                    if (r_in_char == CH_GREATER) begin
                        c_valid = 1'b1; c_kind = K_NJOIN; n_phase = PH_IDLE;
                    end else begin
                        do_sb = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (is_letter(r_in_char) || is_digit(r_in_char)) begin
                        n_count = cnt_p1;
                    end else begin
                        b_valid = 1'b1; b_kind = K_NAME; b_lex = 1'b1; do_sb = 1'b1;
                    end
                end
                PH_NUM: begin
                    if (is_digit(r_in_char)) begin
                        n_count = cnt_p1;
                    end else if (r_in_char == CH_DOT) begin
                        n_phase = PH_NUMDOT;
                    end else begin
                        b_valid = 1'b1;
                        b_kind  = r_saw ? K_FLOAT : K_INT;
                        b_lex   = 1'b1;
                        do_sb   = 1'b1;
                    end
                end
                PH_NUMDOT: begin
                    if (r_in_char == CH_DOT) begin
                        // number ends before a range operator
                        b_valid = 1'b1;
                        b_kind  = r_saw ? K_FLOAT : K_INT;
                        b_lex   = 1'b1;
                        c_valid = 1'b1;
                        c_kind  = K_RANGE;
                        n_phase = PH_IDLE;
                    end else begin
                        // the held dot joins the number
                        n_saw = 1'b1;
                        if (is_digit(r_in_char)) begin
                            n_count = cnt_p2;
                            n_phase = PH_NUM;
                        end else begin
                            b_valid = 1'b1;
                            b_kind  = K_FLOAT;
                            b_lex   = 1'b1;
                            b_size  = cnt_p1;
                            n_count = cnt_p1;
                            do_sb   = 1'b1;
                        end
                    end
                end
                default: do_sb = 1'b1;
            endcase

            if (do_sb) begin
                n_phase = sb_phase;
                if (sb_tok_valid) begin
                    c_valid = 1'b1;
                    c_kind  = sb_kind;
                end
                if (sb_nl) begin
                    n_line = line_p1;
                end
                if (sb_lex) begin
                    n_begin = r_pos;
                    n_count = LENGTH_BITS'(1);
                    n_saw   = 1'b0;
                end
            end
        end
    end

    always_comb begin
        tok_a.kind   = K_SOF;
        tok_a.line   = TOKEN_LINE_W'(r_line);
        tok_a.offset = '0;
        tok_a.size   = '0;
        tok_a.last   = 1'b0;

        tok_b.kind   = b_kind;
        tok_b.line   = TOKEN_LINE_W'(r_line);
        tok_b.offset = b_lex ? TOKEN_OFFSET_W'(r_begin) : '0;
        tok_b.size   = b_lex ? TOKEN_SIZE_W'(b_size) : '0;
        tok_b.last   = 1'b0;

        tok_c.kind   = c_kind;
        tok_c.line   = TOKEN_LINE_W'(r_line);
        tok_c.offset = '0;
        tok_c.size   = '0;
        tok_c.last   = 1'b1;

        // SOF and a flushed token never occur together, so the second slot is always C
        priority if (a_valid) begin
            tok_first = tok_a;
        end else if (b_valid) begin
            tok_first = tok_b;
        end else begin
            tok_first = tok_c;
        end
        tok_second = tok_c;
        push_cnt   = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid};
        if (push_cnt == 2'd1) begin
            tok_first.last = 1'b1;
        end
    end

    assign pending_slots  = {1'b0, r_fifo_cnt} + (r_in_valid ? (CNT_W+1)'(2) : '0);
    assign i_text.ready   = (pending_slots <= (CNT_W+1)'(DEPTH - 2));
    assign in_xfer        = i_text.valid && i_text.ready;
    assign o_token.valid  = (r_fifo_cnt != '0);
    assign out_xfer       = o_token.valid && o_token.ready;

    assign o_token.token_kind    = r_queue[r_rd_ptr].kind;
    assign o_token.token_line    = r_queue[r_rd_ptr].line;
    assign o_token.lexeme_offset = r_queue[r_rd_ptr].offset;
    assign o_token.lexeme_size   = r_queue[r_rd_ptr].size;
    assign o_token.last_of_run   = r_queue[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_START;
            r_line     <= LINE_BITS'(1);
            r_pos      <= '0;
            r_count    <= '0;
            r_saw      <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            r_in_valid <= in_xfer;
            if (r_in_valid) begin
                r_phase <= n_phase;
                r_line  <= n_line;
                r_pos   <= n_pos;
                r_count <= n_count;
                r_saw   <= n_saw;
            end
            if (r_in_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt + (r_in_valid ? CNT_W'(push_cnt) : '0)
                          - (out_xfer ? CNT_W'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_text.text_char;
        end
        if (r_in_valid) begin
            r_begin <= n_begin;
            if (push_cnt != 2'd0) begin
                r_queue[r_wr_ptr] <= tok_first;
            end
            if (push_cnt == 2'd2) begin
                r_queue[r_wr_ptr + 1'b1] <= tok_second;
            end
        end
    end

`include "source_text_lexer_assert.svh"

    `STL_ASSERT_NOW(a_queue_room, i_clk, i_rst_n, r_in_valid,
        ({1'b0, r_fifo_cnt} + (CNT_W+1)'(push_cnt) <= (CNT_W+1)'(DEPTH)),
        "token queue overflow")
    `STL_ASSERT_NOW(a_eof_last, i_clk, i_rst_n,
        o_token.valid && (o_token.token_kind == K_EOF), o_token.last_of_run,
        "EOF token without last_of_run")
    `STL_ASSERT_NOW(a_sof_line, i_clk, i_rst_n,
        o_token.valid && (o_token.token_kind == K_SOF),
        o_token.token_line == TOKEN_LINE_W'(1), "SOF token not on line one")
    `STL_ASSERT_NEXT(a_restart, i_clk, i_rst_n,
        r_in_valid && (r_in_char == CH_NUL), (r_phase == PH_START) && (r_pos == '0),
        "text end did not restart the lexer")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import stl_pkg::*;

    localparam t_char CH_SPACE = 8'h20;
    localparam int HOLD_CYCLES = 200;
    localparam int LONG_NAME_BYTES = 40;
    localparam int TOTAL_BYTES = 950;

    localparam t_char SINGLE_OPS [0:7] = '{
        CH_PLUS, CH_STAR, CH_PERCENT, CH_EQUAL, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK
    };
    localparam t_char PAIR_FIRST [0:5] = '{
        CH_MINUS, CH_SLASH, CH_LESS, CH_GREATER, CH_DOT, CH_BAR
    };
    localparam t_char PAIR_SECOND [0:5] = '{
        CH_GREATER, CH_EQUAL, CH_EQUAL, CH_EQUAL, CH_DOT, CH_GREATER
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stl_char_if text_if ();
    stl_tok_if tok_bus ();

    source_text_lexer i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_text(text_if),
        .o_token(tok_bus)
    );

    always #1 i_clk = ~i_clk;

    // Lexer state as predicted from the accepted bytes
    t_phase                    lex_phase = PH_START;
    logic [TOKEN_LINE_W-1:0]   line_cnt = TOKEN_LINE_W'(1);
    logic [TOKEN_OFFSET_W-1:0] byte_pos = '0;
    logic [TOKEN_OFFSET_W-1:0] lex_begin = '0;
    logic [TOKEN_SIZE_W-1:0]   lex_len = '0;
    logic                      saw_dot = 1'b0;

    t_token predicted_tokens[$];
    int     mismatch_count = 0;
    int     sent_count = 0;
    bit     tx_idle_en = 1'b1;
    bit     rx_idle_en = 1'b1;
    int     hold_request = 0;

    function automatic bit is_letter(t_char c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            || c == CH_UNDER;
    endfunction

    function automatic bit is_digit(t_char c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void push_token(t_kind kind, logic [TOKEN_OFFSET_W-1:0] offset,
                                       logic [TOKEN_SIZE_W-1:0] size);
        t_token tok;
        tok.kind = kind;
        tok.line = line_cnt;
        tok.offset = offset;
        tok.size = size;
        tok.last = 1'b0;
        predicted_tokens.push_back(tok);
    endfunction

    function automatic void push_number();
        push_token(saw_dot ? K_FLOAT : K_INT, lex_begin, lex_len);
    endfunction

    function automatic void grow_lexeme();
        if (lex_len != '1) lex_len++;
    endfunction

    function automatic void start_char(t_char c);
        lex_phase = PH_IDLE;
        case (c)
            CH_NL: if (line_cnt != '1) line_cnt++;
            CH_SEMI: lex_phase = PH_COMMENT;
            CH_DOT: lex_phase = PH_DOT;
            CH_BAR: lex_phase = PH_BAR;
            CH_MINUS: lex_phase = PH_MINUS;
            CH_SLASH: lex_phase = PH_SLASH;
            CH_LESS: lex_phase = PH_LESS;
            CH_GREATER: lex_phase = PH_GREATER;
            CH_PLUS: push_token(K_PLUS, '0, '0);
            CH_STAR: push_token(K_TIMES, '0, '0);
            CH_PERCENT: push_token(K_MOD, '0, '0);
            CH_EQUAL: push_token(K_EQU, '0, '0);
            CH_LPAREN: push_token(K_LPAREN, '0, '0);
            CH_RPAREN: push_token(K_RPAREN, '0, '0);
            CH_LBRACK: push_token(K_LBRACK, '0, '0);
            CH_RBRACK: push_token(K_RBRACK, '0, '0);
            default: begin
                if (is_letter(c) || is_digit(c)) begin
                    lex_phase = is_digit(c) ? PH_NUM : PH_NAME;
                    lex_begin = byte_pos;
                    lex_len = TOKEN_SIZE_W'(1);
                    saw_dot = 1'b0;
                end
            end
        endcase
    endfunction

    // Resolve a held first character: the pair if c completes it, else the single, if any, and c.
    function automatic void pair_or_single(t_char c, t_char second, t_kind pair_kind,
                                           t_kind single_kind, bit has_single);
        lex_phase = PH_IDLE;
        if (c == second) begin
            push_token(pair_kind, '0, '0);
        end else begin
            if (has_single) push_token(single_kind, '0, '0);
            start_char(c);
        end
    endfunction

    function automatic void number_char(t_char c);
        if (is_digit(c)) begin
            grow_lexeme();
        end else if (c == CH_DOT) begin
            lex_phase = PH_NUMDOT;
        end else begin
            push_number();
            start_char(c);
        end
    endfunction

    function automatic void lex_char(t_char c);
        int     n_queued;
        t_token tok;
        n_queued = predicted_tokens.size();
        if (lex_phase == PH_START) begin
            push_token(K_SOF, '0, '0);
            lex_phase = PH_IDLE;
        end
        if (c == CH_NUL) begin
            // flush what is pending, then restart for the next text
            case (lex_phase)
                PH_MINUS: push_token(K_MINUS, '0, '0);
                PH_SLASH: push_token(K_DIV, '0, '0);
                PH_LESS: push_token(K_LT, '0, '0);
                PH_GREATER: push_token(K_GT, '0, '0);
                PH_NAME: push_token(K_NAME, lex_begin, lex_len);
                PH_NUM: push_number();
                PH_NUMDOT: begin
                    grow_lexeme();
                    saw_dot = 1'b1;
                    push_number();
                end
                default: ;
            endcase
            push_token(K_EOF, '0, '0);
            lex_phase = PH_START;
            line_cnt = TOKEN_LINE_W'(1);
            byte_pos = '0;
            lex_begin = '0;
            lex_len = '0;
            saw_dot = 1'b0;
        end else begin
            case (lex_phase)
                PH_COMMENT: if (c == CH_NL) start_char(c);
                PH_MINUS: pair_or_single(c, CH_GREATER, K_ARROW, K_MINUS, 1'b1);
                PH_SLASH: pair_or_single(c, CH_EQUAL, K_NEQ, K_DIV, 1'b1);
                PH_LESS: pair_or_single(c, CH_EQUAL, K_LTEQ, K_LT, 1'b1);
                PH_GREATER: pair_or_single(c, CH_EQUAL, K_GTEQ, K_GT, 1'b1);
                PH_DOT: pair_or_single(c, CH_DOT, K_RANGE, K_RANGE, 1'b0);
                PH_BAR: pair_or_single(c, CH_GREATER, K_NJOIN, K_NJOIN, 1'b0);
                PH_NAME: begin
                    if (is_letter(c) || is_digit(c)) begin
                        grow_lexeme();
                    end else begin
                        push_token(K_NAME, lex_begin, lex_len);
                        start_char(c);
                    end
                end
                PH_NUMDOT: begin
                    if (c == CH_DOT) begin
                        push_number();
                        push_token(K_RANGE, '0, '0);
                        lex_phase = PH_IDLE;
                    end else begin
                        // the held dot belongs to the number
                        grow_lexeme();
                        saw_dot = 1'b1;
                        lex_phase = PH_NUM;
                        number_char(c);
                    end
                end
                PH_NUM: number_char(c);
                default: start_char(c);
            endcase
            if (byte_pos != '1) byte_pos++;
        end
        if (predicted_tokens.size() > n_queued) begin
            tok = predicted_tokens.pop_back();
            tok.last = 1'b1;
            predicted_tokens.push_back(tok);
        end
    endfunction

    // Check each token transfer, then predict from each byte transfer.
    always @(posedge i_clk) begin : token_monitor
        t_token got;
        t_token want;
        if (i_rst_n) begin
            if (tok_bus.valid && tok_bus.ready) begin
                got.kind = tok_bus.token_kind;
                got.line = tok_bus.token_line;
                got.offset = tok_bus.lexeme_offset;
                got.size = tok_bus.lexeme_size;
                got.last = tok_bus.last_of_run;
                if (predicted_tokens.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected token: kind %0d line %0d offset %0d size %0d last %0d",
                                 got.kind, got.line, got.offset, got.size, got.last);
                end else begin
                    want = predicted_tokens.pop_front();
                    if (got.kind !== want.kind || got.line !== want.line
                        || got.offset !== want.offset || got.size !== want.size
                        || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("token mismatch: expected kind %0d line %0d offset %0d size %0d last %0d",
                                     want.kind, want.line, want.offset, want.size, want.last);
                            $display("                got      kind %0d line %0d offset %0d size %0d last %0d",
                                     got.kind, got.line, got.offset, got.size, got.last);
                        end
                    end
                end
            end
            if (text_if.valid && text_if.ready) lex_char(text_if.text_char);
        end
    end

    initial begin : token_receiver
        int stall;
        tok_bus.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, 3) : 0;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                tok_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tok_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_bus.valid);
        end
    end

    task automatic send_char(t_char c);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_if.valid <= 1'b1;
        text_if.text_char <= c;
        do @(posedge i_clk); while (!text_if.ready);
        sent_count++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(t_char'(s[i]));
    endtask

    task automatic wait_drained();
        text_if.valid <= 1'b0;
        // let the monitor predict from the last byte transfer first
        @(posedge i_clk);
        while (predicted_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_char random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return t_char'(CH_UPPER_A + r);
        if (r < 52) return t_char'(CH_LOWER_A + r - 26);
        return CH_UNDER;
    endfunction

    function automatic t_char random_digit();
        return t_char'(CH_0 + $urandom_range(0, 9));
    endfunction

    function automatic t_char random_word_char();
        return ($urandom_range(0, 3) == 0) ? random_digit() : random_letter();
    endfunction

    task automatic test_empty_text();
        send_char(CH_NUL);
        wait_drained();
    endtask

    // Every operator, every pair, every pending single, lone dot and bar, trailing dot.
    task automatic test_operators();
        send_text("+*%=()[]->/=<=>=..|>-/<>.|1.");
        send_char(CH_NUL);
        wait_drained();
    endtask

    task automatic test_names_and_comments();
        send_text("_aZ9;q\n3..4");
        send_char(CH_NUL);
        wait_drained();
    endtask

    // Ignored high byte, then a comment cut short by the end of text.
    task automatic test_odd_bytes();
        send_char(8'hFF);
        send_char(CH_SEMI);
        send_char(CH_NUL);
        wait_drained();
    endtask

    // Hold the token side off while bytes keep coming, so the input stalls.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_char(CH_PLUS);
        send_char(CH_NUL);
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_long_name();
        tx_idle_en = 1'b0;
        send_char(CH_LOWER_A);
        repeat (LONG_NAME_BYTES - 1) send_char(random_word_char());
        send_char(CH_SPACE);
        send_char(CH_NUL);
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic send_random_lexeme();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_char(SINGLE_OPS[$urandom_range(0, 7)]);
        end else if (pick < 30) begin
            idx = $urandom_range(0, 5);
            send_char(PAIR_FIRST[idx]);
            send_char(PAIR_SECOND[idx]);
        end else if (pick < 50) begin
            send_char(random_letter());
            repeat ($urandom_range(0, 6)) send_char(random_word_char());
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 4)) send_char(random_digit());
            if ($urandom_range(0, 1) == 1) begin
                send_char(CH_DOT);
                if ($urandom_range(0, 3) == 0) send_char(CH_DOT);
                repeat ($urandom_range(0, 3)) send_char(random_digit());
            end
        end else if (pick < 72) begin
            send_char(CH_NL);
        end else if (pick < 77) begin
            send_char(CH_SEMI);
            repeat ($urandom_range(0, 5)) send_char(t_char'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) != 0) send_char(CH_NL);
        end else if (pick < 83) begin
            send_char(PAIR_FIRST[$urandom_range(0, 5)]);
        end else if (pick < 92) begin
            send_char(CH_SPACE);
        end else begin
            send_char(t_char'($urandom_range(1, 255)));
        end
    endtask

    task automatic test_random_texts();
        while (sent_count < TOTAL_BYTES) begin
            // some texts run with no idling on one side or both
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 20)) begin
                send_random_lexeme();
            end
            send_char(CH_NUL);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        text_if.valid <= 1'b0;
        text_if.text_char <= CH_NUL;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_text();
        test_operators();
        test_names_and_comments();
        test_odd_bytes();
        test_backpressure();
        test_long_name();
        test_random_texts();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_tokens.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_char_if.sv
rtl/stl_token_if.sv
rtl/source_text_lexer.sv
bench/tb_top.sv
